/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the field splitter, used by its top level.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication or plain property at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/ufs_pkg.sv */
// Types and constants of the UTF-8 field splitter.
// No dependencies; used by ufs_step, ufs_result_fifo and the top level.
package ufs_pkg;

    localparam int unsigned BUFFER_BYTES = 4096;
    // A byte outside a character arriving at this length or more closes the field with a limit error.
    localparam int unsigned LIMIT = BUFFER_BYTES - 5;

    localparam int LEN_W = 12;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_CONT = 8'h80;
    localparam logic [7:0] BYTE_LEAD2 = 8'hC0;
    localparam logic [7:0] BYTE_LEAD3 = 8'hE0;
    localparam logic [7:0] BYTE_LEAD4 = 8'hF0;
    localparam logic [7:0] BYTE_BAD = 8'hF8;
    localparam logic [7:0] BYTE_EOF = 8'hFF;

    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_TERM = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_STRAY = 2'd1;
    localparam logic [1:0] CAUSE_BAD_LEAD = 2'd2;
    localparam logic [1:0] CAUSE_LIMIT = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] field_length;
        logic [LEN_W-1:0] max_length;
        logic [1:0]       error_cause;
        logic             is_last;
    } result_t;

endpackage

/* hdl/ufs_step.sv */
// Per-byte tokenizer logic and the field state registers.
// Depends on ufs_pkg for result_t and the byte and code constants.
module ufs_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [7:0]          byte_in,
    output ufs_pkg::result_t    res_first,
    output ufs_pkg::result_t    res_second,
    output logic                res_two
);

    logic [1:0]                 pend_reg, pend_next;
    logic [ufs_pkg::LEN_W-1:0]  cur_reg, cur_next;
    logic [ufs_pkg::LEN_W-1:0]  max_reg, max_next;

    logic                       at_limit;
    logic [ufs_pkg::LEN_W-1:0]  cur_b;
    logic [ufs_pkg::LEN_W-1:0]  max_b;
    logic [ufs_pkg::LEN_W-1:0]  max_end;
    logic [2:0]                 add_n;
    logic [ufs_pkg::LEN_W:0]    sum;
    logic [ufs_pkg::LEN_W-1:0]  cur_add;
    ufs_pkg::result_t           lim_res;
    ufs_pkg::result_t           main_res;

    always_comb
    begin
        at_limit = ({20'd0, cur_reg} >= 32'(ufs_pkg::LIMIT));
        // After a limit error the byte is handled against an empty field.
        cur_b = at_limit ? '0 : cur_reg;
        max_b = (at_limit && (cur_reg > max_reg)) ? cur_reg : max_reg;
        max_end = (cur_b > max_b) ? cur_b : max_b;

        if (byte_in < ufs_pkg::BYTE_CONT)
            add_n = 3'd1;
        else if (byte_in < ufs_pkg::BYTE_LEAD3)
            add_n = 3'd2;
        else if (byte_in < ufs_pkg::BYTE_LEAD4)
            add_n = 3'd3;
        else
            add_n = 3'd4;
        sum = {1'b0, cur_b} + {{(ufs_pkg::LEN_W-2){1'b0}}, add_n};
        cur_add = sum[ufs_pkg::LEN_W] ? ufs_pkg::LEN_MAX : sum[ufs_pkg::LEN_W-1:0];

        lim_res.kind = ufs_pkg::KIND_ERROR;
        lim_res.data_byte = 8'd0;
        lim_res.field_length = cur_reg;
        lim_res.max_length = max_b;
        lim_res.error_cause = ufs_pkg::CAUSE_LIMIT;
        lim_res.is_last = 1'b0;

        main_res.kind = ufs_pkg::KIND_CONTENT;
        main_res.data_byte = byte_in;
        main_res.field_length = cur_reg;
        main_res.max_length = max_reg;
        main_res.error_cause = ufs_pkg::CAUSE_NONE;
        main_res.is_last = 1'b1;

        pend_next = pend_reg;
        cur_next = cur_reg;
        max_next = max_reg;

        if (pend_reg != 2'd0)
        begin
            // Continuation bytes pass through without any check.
            pend_next = pend_reg - 2'd1;
        end
        else
        begin
            main_res.max_length = max_b;
            max_next = max_b;
            cur_next = cur_b;
            if ((byte_in < ufs_pkg::BYTE_SPACE) || (byte_in == ufs_pkg::BYTE_EOF))
            begin
                main_res.kind = ufs_pkg::KIND_TERM;
                main_res.field_length = cur_b;
                main_res.max_length = max_end;
                max_next = max_end;
                cur_next = '0;
            end
            else if ((byte_in < ufs_pkg::BYTE_LEAD2) && (byte_in >= ufs_pkg::BYTE_CONT))
            begin
                main_res.kind = ufs_pkg::KIND_ERROR;
                main_res.data_byte = 8'd0;
                main_res.field_length = cur_b;
                main_res.max_length = max_end;
                main_res.error_cause = ufs_pkg::CAUSE_STRAY;
                max_next = max_end;
                cur_next = '0;
            end
            else if (byte_in >= ufs_pkg::BYTE_BAD)
            begin
                main_res.kind = ufs_pkg::KIND_ERROR;
                main_res.data_byte = 8'd0;
                main_res.field_length = cur_b;
                main_res.max_length = max_end;
                main_res.error_cause = ufs_pkg::CAUSE_BAD_LEAD;
                max_next = max_end;
                cur_next = '0;
            end
            else
            begin
                main_res.field_length = cur_add;
                cur_next = cur_add;
                pend_next = add_n[1:0] - 2'd1;
            end
        end

        res_two = (pend_reg == 2'd0) && at_limit;
        res_first = res_two ? lim_res : main_res;
        res_second = main_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            cur_reg <= '0;
            max_reg <= '0;
        end
        else if (go)
        begin
            pend_reg <= pend_next;
            cur_reg <= cur_next;
            max_reg <= max_next;
        end
    end

endmodule

/* hdl/ufs_result_fifo.sv */
// Four-entry result queue that takes one or two results per cycle.
// Depends on ufs_pkg for result_t and the queue sizes.
module ufs_result_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                push_two,
    input  ufs_pkg::result_t    wr_first,
    input  ufs_pkg::result_t    wr_second,
    output logic                room_two,
    output logic                out_valid,
    input  logic                out_ready,
    output ufs_pkg::result_t    rd_data
);

    ufs_pkg::result_t               mem_reg [ufs_pkg::FIFO_DEPTH];
    logic [ufs_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ufs_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ufs_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [ufs_pkg::PTR_W-1:0]      wr_ptr_second;
    logic                           pop;
    logic [ufs_pkg::CNT_W-1:0]      n_push;

    always_comb
    begin
        pop = out_valid && out_ready;
        n_push = push ? (push_two ? ufs_pkg::CNT_W'(2) : ufs_pkg::CNT_W'(1))
                      : ufs_pkg::CNT_W'(0);
        wr_ptr_second = wr_ptr_reg + ufs_pkg::PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + n_push[ufs_pkg::PTR_W-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + ufs_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + n_push - ufs_pkg::CNT_W'(pop);
    end

    assign room_two = (count_reg <= ufs_pkg::CNT_W'(ufs_pkg::FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_first;
            if (push_two)
                mem_reg[wr_ptr_second] <= wr_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/utf8_field_splitter_top.sv */
// Top level of the UTF-8 field splitter: input register, tokenizer, result queue.
// Depends on ufs_pkg, ufs_step, ufs_result_fifo and assert_macros.svh.
//
//  channel | direction | signals                                   | per transfer
//  --------+-----------+-------------------------------------------+---------------
//  in      | in        | in_valid, in_ready, byte_in               | one raw byte
//  out     | out       | out_valid, out_ready, kind, data_byte,    | one result
//          |           | field_length, max_length, error_cause,    |
//          |           | is_last                                   |
//
// One byte is taken every cycle while the queue has room for two results; its results pass
// through the input register and the queue. A byte that closes a field at the length limit
// yields two results, and the output port sets the rate then: one result per cycle.
// The input register feeds the queue only while it has room for two results, so a stall on
// the output fills the four-entry queue to three or four results and then holds in_ready low.
// Reset is asynchronous and empties the input register and queue and clears all lengths.
`include "assert_macros.svh"

module utf8_field_splitter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [11:0] field_length,
    output logic [11:0] max_length,
    output logic [1:0]  error_cause,
    output logic        is_last
);

    logic               vld_reg;
    logic [7:0]         byte_reg;
    logic               stage_go;
    logic               room_two;
    ufs_pkg::result_t   res_first;
    ufs_pkg::result_t   res_second;
    logic               res_two;
    ufs_pkg::result_t   rd_data;

    assign stage_go = vld_reg && room_two;
    assign in_ready = !vld_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= byte_in;
    end

    ufs_step u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (stage_go),
        .byte_in    (byte_reg),
        .res_first  (res_first),
        .res_second (res_second),
        .res_two    (res_two)
    );

    ufs_result_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (stage_go),
        .push_two   (res_two),
        .wr_first   (res_first),
        .wr_second  (res_second),
        .room_two   (room_two),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rd_data    (rd_data)
    );

    assign kind = rd_data.kind;
    assign data_byte = rd_data.data_byte;
    assign field_length = rd_data.field_length;
    assign max_length = rd_data.max_length;
    assign error_cause = rd_data.error_cause;
    assign is_last = rd_data.is_last;

    // Only a limit error is followed by a second result from the same byte.
    `ASSERT_AT(a_not_last_is_limit, clk, rst_n, (out_valid && !is_last) |-> (kind == ufs_pkg::KIND_ERROR && error_cause == ufs_pkg::CAUSE_LIMIT), "result that is not last must be a limit error")
    // Both results of a byte are queued together, so the second is ready at once.
    `ASSERT_AT(a_second_ready, clk, rst_n, (out_valid && out_ready && !is_last) |=> out_valid, "second result of a byte is missing")
    `ASSERT_NEVER(a_end_above_max, clk, rst_n, out_valid && kind != ufs_pkg::KIND_CONTENT && field_length > max_length, "field end longer than running maximum")
    `ASSERT_AT(a_error_has_cause, clk, rst_n, (out_valid && kind == ufs_pkg::KIND_ERROR) |-> (error_cause != ufs_pkg::CAUSE_NONE && data_byte == 8'd0), "error end without cause or with data")

endmodule

/* test/ufs_result_checker.sv */
// Result checker for the UTF-8 field splitter: predicts the results of every input
// transfer and compares them with the output transfers. Depends on ufs_pkg.
module ufs_result_checker
    import ufs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       byte_in,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [1:0]       kind,
    input  logic [7:0]       data_byte,
    input  logic [LEN_W-1:0] field_length,
    input  logic [LEN_W-1:0] max_length,
    input  logic [1:0]       error_cause,
    input  logic             is_last,
    output int               fail_count,
    output int               waiting_count,
    output int               result_count,
    output int               field_end_count,
    output int               limit_close_count
);

    logic [1:0]       cont_left;
    logic [LEN_W-1:0] open_len;
    logic [LEN_W-1:0] longest_len;
    result_t          token_q[$];
    int               fail_total;
    int               seen_total;
    int               end_total;
    int               limit_total;

    task automatic emit_token(input logic [1:0] k, input logic [7:0] d,
                              input logic [LEN_W-1:0] len, input logic [1:0] cause,
                              input logic last);
        result_t t;
        t.kind         = k;
        t.data_byte    = d;
        t.field_length = len;
        t.max_length   = longest_len;
        t.error_cause  = cause;
        t.is_last      = last;
        token_q.push_back(t);
    endtask

    task automatic close_field(input logic [1:0] k, input logic [7:0] d,
                               input logic [1:0] cause, input logic last);
        if (open_len > longest_len)
            longest_len = open_len;
        emit_token(k, d, open_len, cause, last);
        open_len  = '0;
        cont_left = '0;
    endtask

    task automatic grow_field(input int n);
        int sum;
        sum = int'(open_len) + n;
        open_len = (sum > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(sum);
    endtask

    task automatic split_byte(input logic [7:0] b);
        int extra;
        if (cont_left != 0)
        begin
            // Continuation bytes pass through without being classified.
            cont_left = cont_left - 2'd1;
            emit_token(KIND_CONTENT, b, open_len, CAUSE_NONE, 1'b1);
        end
        else
        begin
            if (open_len >= LIMIT)
                close_field(KIND_ERROR, 8'h00, CAUSE_LIMIT, 1'b0);
            if (b < BYTE_SPACE || b == BYTE_EOF)
                close_field(KIND_TERM, b, CAUSE_NONE, 1'b1);
            else if (b < BYTE_CONT)
            begin
                grow_field(1);
                emit_token(KIND_CONTENT, b, open_len, CAUSE_NONE, 1'b1);
            end
            else if (b < BYTE_LEAD2)
                close_field(KIND_ERROR, 8'h00, CAUSE_STRAY, 1'b1);
            else if (b < BYTE_BAD)
            begin
                extra = (b < BYTE_LEAD3) ? 1 : (b < BYTE_LEAD4) ? 2 : 3;
                grow_field(extra + 1);
                cont_left = 2'(extra);
                emit_token(KIND_CONTENT, b, open_len, CAUSE_NONE, 1'b1);
            end
            else
                close_field(KIND_ERROR, 8'h00, CAUSE_BAD_LEAD, 1'b1);
        end
    endtask

    task automatic check_token();
        result_t want;
        seen_total++;
        if (token_q.size() == 0)
        begin
            fail_total++;
            if (fail_total <= 10)
                $display("[%0t] unexpected result: kind=%0d data=%02h len=%0d max=%0d",
                         $realtime, kind, data_byte, field_length, max_length);
        end
        else
        begin
            want = token_q.pop_front();
            if (want.kind != KIND_CONTENT)
                end_total++;
            if (want.error_cause == CAUSE_LIMIT)
                limit_total++;
            if (kind !== want.kind || data_byte !== want.data_byte
                || field_length !== want.field_length || max_length !== want.max_length
                || error_cause !== want.error_cause || is_last !== want.is_last)
            begin
                fail_total++;
                if (fail_total <= 10)
                begin
                    $display("[%0t] mismatch: expected kind=%0d data=%02h len=%0d max=%0d",
                             $realtime, want.kind, want.data_byte, want.field_length,
                             want.max_length, " cause=%0d last=%0d", want.error_cause,
                             want.is_last);
                    $display("           actual   kind=%0d data=%02h len=%0d max=%0d",
                             kind, data_byte, field_length, max_length,
                             " cause=%0d last=%0d", error_cause, is_last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_left   = '0;
            open_len    = '0;
            longest_len = '0;
            token_q.delete();
            fail_total  = 0;
            seen_total  = 0;
            end_total   = 0;
            limit_total = 0;
            fail_count        <= 0;
            waiting_count     <= 0;
            result_count      <= 0;
            field_end_count   <= 0;
            limit_close_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                split_byte(byte_in);
            if (out_valid && out_ready)
                check_token();
            fail_count        <= fail_total;
            waiting_count     <= token_q.size();
            result_count      <= seen_total;
            field_end_count   <= end_total;
            limit_close_count <= limit_total;
        end
    end

endmodule

/* test/tb_utf8_field_splitter_top.sv */
// Testbench top for the UTF-8 field splitter: clock, reset, byte stimulus and verdict.
// Depends on ufs_pkg, utf8_field_splitter_top and ufs_result_checker.
module tb_utf8_field_splitter_top;
    import ufs_pkg::*;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_BYTES = 920;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       byte_in;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] field_length;
    logic [LEN_W-1:0] max_length;
    logic [1:0]       error_cause;
    logic             is_last;

    int fail_count;
    int waiting_count;
    int result_count;
    int field_end_count;
    int limit_close_count;

    int cycle_count = 0;
    int bytes_sent  = 0;
    bit quiet       = 1'b0;

    utf8_field_splitter_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .field_length (field_length),
        .max_length   (max_length),
        .error_cause  (error_cause),
        .is_last      (is_last)
    );

    ufs_result_checker result_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .byte_in           (byte_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .data_byte         (data_byte),
        .field_length      (field_length),
        .max_length        (max_length),
        .error_cause       (error_cause),
        .is_last           (is_last),
        .fail_count        (fail_count),
        .waiting_count     (waiting_count),
        .result_count      (result_count),
        .field_end_count   (field_end_count),
        .limit_close_count (limit_close_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        // Now and then both sides run without any idle cycles for a while.
        if (cycle_count % 300 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, waiting_count);
            $display("FAIL utf8_field_splitter_top");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet)
                    stall_left = pick_gap();
            end
        end
    end

    // Called and returning at a falling edge; the transfer happens at a rising edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // One character with a valid lead byte; continuation bytes may hold any value.
    task automatic send_char();
        int pick;
        int extra;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            send_byte(8'($urandom_range(8'h20, 8'h7F)));
        end
        else
        begin
            extra = (pick < 8) ? 1 : (pick == 8) ? 2 : 3;
            if (extra == 1)
                send_byte(8'($urandom_range(8'hC0, 8'hDF)));
            else if (extra == 2)
                send_byte(8'($urandom_range(8'hE0, 8'hEF)));
            else
                send_byte(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (extra)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_byte(8'($urandom_range(8'h80, 8'hBF)));
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_field_end();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_byte(8'($urandom_range(8'h00, 8'h1F)));
        else if (pick < 70)
            send_byte(BYTE_EOF);
        else if (pick < 85)
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        else
            send_byte(8'($urandom_range(8'hF8, 8'hFE)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (waiting_count != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] opening[$];
        int         random_start;
        int         n;
        bit         paused;

        opening = '{8'h20, 8'h7F, 8'h41, 8'h0A, 8'h00,
                    8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h1F,
                    8'hDF, 8'hFF, 8'h80,
                    8'hEF, 8'h00, 8'h0A, 8'hBF,
                    8'hF8,
                    8'hF7, 8'hFE, 8'h1F, 8'h7E, 8'hFE,
                    8'hFF};
        paused  = 1'b0;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        byte_in  = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            send_byte(opening[i]);
        wait_drained();

        // Mostly well-formed fields with random content, some raw noise in between.
        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120)
                                                 : $urandom_range(0, 12);
                repeat (n) send_char();
                send_field_end();
            end
            if (!paused && bytes_sent > random_start + RANDOM_BYTES / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);

        $display("Sent %0d bytes; checked %0d results with %0d field ends,",
                 bytes_sent, result_count, field_end_count);
        $display("%0d of them closed at the length limit.", limit_close_count);
        if (fail_count == 0 && waiting_count == 0)
            $display("PASS utf8_field_splitter_top");
        else
            $display("FAIL utf8_field_splitter_top");
        $finish;
    end

endmodule
